// ===== rtl/mtep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and codes for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // Defaults and fixed field widths
    localparam int LEN_WIDTH_DEF = 32;
    localparam int EVT_LEN_W     = 32;
    localparam int TEMPO_W       = 24;
    localparam int PARAM1_W      = 14;

    // Status bytes and channel message nibbles
    localparam logic [7:0] STATUS_SYSEX = 8'hF0;
    localparam logic [7:0] STATUS_META  = 8'hFF;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRS = 4'hD;
    localparam logic [3:0] NIB_PITCH    = 4'hE;
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;

    // Meta types with a fixed payload length
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_SMPTE   = 8'h54;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] META_KEYSIG  = 8'h59;

    // Event classes
    localparam logic [1:0] CLS_CHANNEL = 2'd0;
    localparam logic [1:0] CLS_SYSEX   = 2'd1;
    localparam logic [1:0] CLS_META    = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNEXP_END  = 3'd1;
    localparam logic [2:0] ERR_NO_RUNNING = 3'd2;
    localparam logic [2:0] ERR_META_LEN   = 3'd3;
    localparam logic [2:0] ERR_BAD_STATUS = 3'd4;

    // Parse phase, one-hot
    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_CH1    = 8'b0000_0010,
        PH_CH2    = 8'b0000_0100,
        PH_SXLEN  = 8'b0000_1000,
        PH_SXSKIP = 8'b0001_0000,
        PH_MTYPE  = 8'b0010_0000,
        PH_MLEN   = 8'b0100_0000,
        PH_MDATA  = 8'b1000_0000
    } t_phase;

    // One result item
    typedef struct packed {
        logic [1:0]           event_class;
        logic [7:0]           event_type;
        logic [3:0]           channel_number;
        logic [PARAM1_W-1:0]  first_param;
        logic [7:0]           second_param;
        logic [TEMPO_W-1:0]   tempo_value;
        logic [EVT_LEN_W-1:0] event_length;
        logic [2:0]           error_code;
        logic                 track_ended;
    } t_result;

    // Phase entered after a status byte
    function automatic t_phase begin_phase(input logic [7:0] status);
        t_phase ph;
        if (status == STATUS_SYSEX) begin
            ph = PH_SXLEN;
        end else if (status == STATUS_META) begin
            ph = PH_MTYPE;
        end else begin
            ph = PH_CH1;
        end
        return ph;
    endfunction

    // Error result: every field but the code is zero
    function automatic t_result make_fail(input logic [2:0] err);
        t_result r;
        r = '0;
        r.error_code = err;
        return r;
    endfunction

endpackage

// ===== rtl/mtep_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_core
// Per-byte parse state and decode. One byte is taken per transfer; the
// result, if any, is produced combinationally for the output buffer.
// ----------------------------------------------------------------------------
module mtep_core #(
    parameter int LENGTH_WIDTH = mtep_pkg::LEN_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_in_buffer,
    input  logic              i_new_track,
    output logic              o_res_valid,
    output mtep_pkg::t_result o_res
);
    import mtep_pkg::*;

    localparam int LW = LENGTH_WIDTH;

    // Parse state
    t_phase                r_phase, n_phase;
    logic                  r_eot, n_eot;
    logic [7:0]            r_rs, n_rs;
    logic [7:0]            r_cur, n_cur;
    logic [7:0]            r_meta, n_meta;
    logic [LW-1:0]         r_la, n_la;
    logic [LW-1:0]         r_pr, n_pr;
    logic [7:0]            r_first, n_first;
    logic [TEMPO_W-1:0]    r_tempo, n_tempo;
    logic [EVT_LEN_W-1:0]  r_cnt, n_cnt;

    // Working values
    t_phase                ph;
    logic                  eot;
    logic                  idle;
    logic                  go;
    logic [7:0]            status;
    logic [LW-1:0]         la_base;
    logic [LW-1:0]         la_shift;
    logic [LW-1:0]         pr_dec;
    logic [TEMPO_W-1:0]    tempo_base;
    logic [EVT_LEN_W-1:0]  cnt_base;
    logic [EVT_LEN_W:0]    cnt_sum;
    logic                  res_valid;
    t_result               res;

    // Length with a declared payload still outstanding, saturating
    function automatic logic [EVT_LEN_W-1:0] sat_len(input logic [EVT_LEN_W-1:0] cnt,
                                                     input logic [LW-1:0] extra);
        logic [EVT_LEN_W:0] s;
        s = {1'b0, cnt} + (EVT_LEN_W+1)'(extra);
        return s[EVT_LEN_W] ? '1 : s[EVT_LEN_W-1:0];
    endfunction

    // Plain success result
    function automatic t_result make_ok(input logic [1:0] cls, input logic [7:0] typ,
                                        input logic [3:0] ch,
                                        input logic [PARAM1_W-1:0] p1,
                                        input logic [7:0] p2,
                                        input logic [TEMPO_W-1:0] tempo,
                                        input logic [EVT_LEN_W-1:0] len,
                                        input logic ended);
        t_result r;
        r.event_class    = cls;
        r.event_type     = typ;
        r.channel_number = ch;
        r.first_param    = p1;
        r.second_param   = p2;
        r.tempo_value    = tempo;
        r.event_length   = len;
        r.error_code     = ERR_NONE;
        r.track_ended    = ended;
        return r;
    endfunction

    // Close a meta event: check fixed lengths, flag end of track
    function automatic t_result finish_meta(input logic [7:0] meta,
                                            input logic [LW-1:0] len,
                                            input logic [TEMPO_W-1:0] tempo,
                                            input logic [EVT_LEN_W-1:0] cnt);
        logic [LW-1:0] need;
        logic          checked;
        t_result       r;
        checked = 1'b1;
        need    = '0;
        case (meta)
            META_EOT:     need = LW'(0);
            META_TEMPO:   need = LW'(3);
            META_SMPTE:   need = LW'(5);
            META_TIMESIG: need = LW'(4);
            META_KEYSIG:  need = LW'(2);
            default:      checked = 1'b0;
        endcase
        if (checked && (len != need)) begin
            r = make_fail(ERR_META_LEN);
        end else if (meta == META_EOT) begin
            r = make_ok(CLS_META, META_EOT, 4'h0, '0, 8'h00, '0, cnt, 1'b1);
        end else begin
            r = make_ok(CLS_META, meta, 4'h0, '0, 8'h00,
                        (meta == META_TEMPO) ? tempo : '0, cnt, 1'b0);
        end
        return r;
    endfunction

    // Decode one byte against the current phase
    always_comb begin
        n_phase   = r_phase;
        n_eot     = r_eot;
        n_rs      = r_rs;
        n_cur     = r_cur;
        n_meta    = r_meta;
        n_la      = r_la;
        n_pr      = r_pr;
        n_first   = r_first;
        n_tempo   = r_tempo;
        n_cnt     = r_cnt;
        res_valid = 1'b0;
        res       = '0;

        // new track drops end of track and any partial event
        ph  = i_new_track ? PH_IDLE : r_phase;
        eot = i_new_track ? 1'b0 : r_eot;
        n_phase = ph;
        n_eot   = eot;

        idle       = (ph == PH_IDLE);
        la_base    = idle ? '0 : r_la;
        tempo_base = idle ? '0 : r_tempo;
        cnt_base   = idle ? '0 : r_cnt;
        cnt_sum    = {1'b0, cnt_base} + (EVT_LEN_W+1)'(1);
        la_shift   = {la_base[LW-8:0], i_data_byte[6:0]};
        pr_dec     = r_pr - LW'(1);
        status     = r_cur;
        go         = 1'b0;

        if (!eot) begin
            n_la    = la_base;
            n_tempo = tempo_base;
            n_cnt   = cnt_sum[EVT_LEN_W] ? '1 : cnt_sum[EVT_LEN_W-1:0];
            go      = 1'b1;

            // event start: new status or running status
            if (idle) begin
                if (i_data_byte[7]) begin
                    n_rs    = i_data_byte;
                    n_cur   = i_data_byte;
                    n_phase = begin_phase(i_data_byte);
                    go      = 1'b0;
                    if (i_last_in_buffer) begin
                        res_valid = 1'b1;
                        res       = make_fail(ERR_UNEXP_END);
                        n_phase   = PH_IDLE;
                    end
                end else if (!r_rs[7]) begin
                    go        = 1'b0;
                    res_valid = 1'b1;
                    res       = make_fail(ERR_NO_RUNNING);
                    n_phase   = PH_IDLE;
                end else begin
                    n_cur  = r_rs;
                    status = r_rs;
                    ph     = begin_phase(r_rs);
                end
            end
        end

        if (go) begin
            case (ph)
                PH_CH1: begin
                    n_first = i_data_byte;
                    if (status[7:4] == NIB_PROGRAM || status[7:4] == NIB_CHAN_PRS) begin
                        res_valid = 1'b1;
                        res = make_ok(CLS_CHANNEL, {status[7:4], 4'h0}, status[3:0],
                                      PARAM1_W'(i_data_byte), 8'h00, '0, n_cnt, 1'b0);
                    end else if (status[7:4] == NIB_SYSTEM) begin
                        res_valid = 1'b1;
                        res       = make_fail(ERR_BAD_STATUS);
                    end else begin
                        n_phase = PH_CH2;
                        if (i_last_in_buffer) begin
                            res_valid = 1'b1;
                            res       = make_fail(ERR_UNEXP_END);
                        end
                    end
                end
                PH_CH2: begin
                    res_valid = 1'b1;
                    if (status[7:4] == NIB_PITCH) begin
                        res = make_ok(CLS_CHANNEL, {status[7:4], 4'h0}, status[3:0],
                                      {i_data_byte[6:0], r_first[6:0]}, 8'h00, '0,
                                      n_cnt, 1'b0);
                    end else begin
                        res = make_ok(CLS_CHANNEL, {status[7:4], 4'h0}, status[3:0],
                                      PARAM1_W'(r_first), i_data_byte, '0, n_cnt, 1'b0);
                    end
                end
                PH_SXLEN: begin
                    n_la    = la_shift;
                    n_phase = PH_SXLEN;
                    if (i_data_byte[7]) begin
                        if (i_last_in_buffer) begin
                            res_valid = 1'b1;
                            res       = make_fail(ERR_UNEXP_END);
                        end
                    end else if (la_shift == '0) begin
                        res_valid = 1'b1;
                        res = make_ok(CLS_SYSEX, STATUS_SYSEX, 4'h0, '0, 8'h00, '0,
                                      n_cnt, 1'b0);
                    end else begin
                        n_pr = la_shift;
                        if (i_last_in_buffer) begin
                            res_valid = 1'b1;
                            res = make_ok(CLS_SYSEX, STATUS_SYSEX, 4'h0, '0, 8'h00, '0,
                                          sat_len(n_cnt, la_shift), 1'b0);
                        end else begin
                            n_phase = PH_SXSKIP;
                        end
                    end
                end
                PH_SXSKIP: begin
                    n_pr = pr_dec;
                    if (pr_dec == '0) begin
                        res_valid = 1'b1;
                        res = make_ok(CLS_SYSEX, STATUS_SYSEX, 4'h0, '0, 8'h00, '0,
                                      n_cnt, 1'b0);
                    end else if (i_last_in_buffer) begin
                        res_valid = 1'b1;
                        res = make_ok(CLS_SYSEX, STATUS_SYSEX, 4'h0, '0, 8'h00, '0,
                                      sat_len(n_cnt, pr_dec), 1'b0);
                    end
                end
                PH_MTYPE: begin
                    n_meta  = i_data_byte;
                    n_la    = '0;
                    n_tempo = '0;
                    n_phase = PH_MLEN;
                    if (i_last_in_buffer) begin
                        res_valid = 1'b1;
                        res       = make_fail(ERR_UNEXP_END);
                    end
                end
                PH_MLEN: begin
                    n_la = la_shift;
                    if (i_data_byte[7]) begin
                        if (i_last_in_buffer) begin
                            res_valid = 1'b1;
                            res       = make_fail(ERR_UNEXP_END);
                        end
                    end else if (la_shift == '0) begin
                        res_valid = 1'b1;
                        res       = finish_meta(r_meta, la_shift, tempo_base, n_cnt);
                    end else begin
                        n_pr    = la_shift;
                        n_phase = PH_MDATA;
                        if (i_last_in_buffer) begin
                            res_valid = 1'b1;
                            res       = make_fail(ERR_UNEXP_END);
                        end
                    end
                end
                PH_MDATA: begin
                    n_tempo = {tempo_base[TEMPO_W-9:0], i_data_byte};
                    n_pr    = pr_dec;
                    if (pr_dec == '0) begin
                        res_valid = 1'b1;
                        res = finish_meta(r_meta, la_base,
                                          {tempo_base[TEMPO_W-9:0], i_data_byte}, n_cnt);
                    end else if (i_last_in_buffer) begin
                        res_valid = 1'b1;
                        res       = make_fail(ERR_UNEXP_END);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            // any result closes the event
            if (res_valid) begin
                n_phase = PH_IDLE;
                if (res.track_ended) begin
                    n_eot = 1'b1;
                end
            end
        end
    end

    // Advance state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_eot   <= 1'b0;
            r_rs    <= 8'h00;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_eot   <= n_eot;
            r_rs    <= n_rs;
        end
    end

    // Hold event payload state
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_cur   <= n_cur;
            r_meta  <= n_meta;
            r_la    <= n_la;
            r_pr    <= n_pr;
            r_first <= n_first;
            r_tempo <= n_tempo;
            r_cnt   <= n_cnt;
        end
    end

    assign o_res_valid = i_take & res_valid;
    assign o_res       = res;

    // An error result carries nothing but its code
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error_code != ERR_NONE) |->
            (o_res.event_length == '0 && o_res.track_ended == 1'b0
             && o_res.event_class == CLS_CHANNEL && o_res.tempo_value == '0))
        else $error("error result carries payload");

    // End of track is only the end-of-track meta event
    a_eot_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.track_ended) |->
            (o_res.event_class == CLS_META && o_res.event_type == META_EOT))
        else $error("track end on wrong event");

    // After end of track, bytes without new track give nothing
    a_eot_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.track_ended) |=>
            !(i_take && !i_new_track && o_res_valid))
        else $error("result after end of track");

    // Every result returns the parser to idle
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == PH_IDLE))
        else $error("result left event open");

endmodule

// ===== rtl/mtep_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_outbuf
// Two-entry result buffer: output register plus skid register, so the
// input side keeps moving while a result waits downstream.
// ----------------------------------------------------------------------------
module mtep_outbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtep_pkg::t_result i_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output mtep_pkg::t_result o_data,
    output logic              o_in_stall
);
    import mtep_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    assign take = r_out_valid & ~i_out_stall;

    // Refill the output register from skid or the new result
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_data      = r_out;
    assign o_in_stall  = r_skid_valid;

    // Skid only fills behind a held output
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid full with output empty");

    // No push lands while the skid is full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_skid_valid))
        else $error("result pushed into full buffer");

endmodule

// ===== rtl/midi_track_event_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser
// MIDI track event parser: running status, channel messages, sysex skip,
// meta length checks and tempo assembly, one byte per transfer.
// ----------------------------------------------------------------------------
// A result is decoded combinationally from the byte that completes its event
//   and is registered in the output buffer before it shows on o_out_valid.
// Throughput: one byte per cycle when not stalled; parse state updates in a single pass.
// The two-entry output buffer lets input continue for one result while the
//   output is stalled; o_in_stall rises only when both entries are full.
// Reset: synchronous, active low; clears phase, running status, end of track, buffer.
module midi_track_event_parser #(
    parameter int LENGTH_WIDTH = mtep_pkg::LEN_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_in_buffer,
    input  logic        i_new_track,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_class,
    output logic [7:0]  o_event_type,
    output logic [3:0]  o_channel_number,
    output logic [13:0] o_first_param,
    output logic [7:0]  o_second_param,
    output logic [23:0] o_tempo_value,
    output logic [31:0] o_event_length,
    output logic [2:0]  o_error_code,
    output logic        o_track_ended
);
    import mtep_pkg::*;

    logic    in_take;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // Input transfer
    assign in_take = i_in_valid & ~o_in_stall;

    mtep_core #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (in_take),
        .i_data_byte      (i_data_byte),
        .i_last_in_buffer (i_last_in_buffer),
        .i_new_track      (i_new_track),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    mtep_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_data      (out_res),
        .o_in_stall  (o_in_stall)
    );

    // Unpack the result onto the ports
    assign o_event_class    = out_res.event_class;
    assign o_event_type     = out_res.event_type;
    assign o_channel_number = out_res.channel_number;
    assign o_first_param    = out_res.first_param;
    assign o_second_param   = out_res.second_param;
    assign o_tempo_value    = out_res.tempo_value;
    assign o_event_length   = out_res.event_length;
    assign o_error_code     = out_res.error_code;
    assign o_track_ended    = out_res.track_ended;

endmodule

// ===== tb/sv/midi_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_event_checker
// Watches both channels of the MIDI track event parser. Every byte taken in
// runs through a local copy of the parse state. Each finished event or error
// goes into a queue. Every result taken out is compared field by field with
// the oldest queued event.
// ----------------------------------------------------------------------------
module midi_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_in_buffer,
    input  logic        i_new_track,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_event_class,
    input  logic [7:0]  i_event_type,
    input  logic [3:0]  i_channel_number,
    input  logic [13:0] i_first_param,
    input  logic [7:0]  i_second_param,
    input  logic [23:0] i_tempo_value,
    input  logic [31:0] i_event_length,
    input  logic [2:0]  i_error_code,
    input  logic        i_track_ended,
    output int          o_pending,
    output int          o_mismatches
);
    import mtep_pkg::*;

    localparam int          LEN_W    = LEN_WIDTH_DEF;
    localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_W) - 64'd1);

    // Parse state mirrored from the block
    logic [7:0]  run_status;
    t_phase      phase;
    logic [7:0]  cur_status;
    logic [7:0]  meta_type;
    logic [31:0] len_acc;
    logic [31:0] payload_left;
    logic [7:0]  first_data;
    logic [23:0] tempo_acc;
    logic [31:0] byte_cnt;
    logic        track_over;

    t_result parsed_events_q[$];
    int      mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Enter the phase that follows a status byte
    function automatic void open_event(input logic [7:0] status);
        cur_status = status;
        if (status == STATUS_SYSEX) begin
            phase = PH_SXLEN;
        end else if (status == STATUS_META) begin
            phase = PH_MTYPE;
        end else begin
            phase = PH_CH1;
        end
    endfunction

    function automatic t_result sysex_result(input logic [31:0] length);
        t_result r;
        r = '0;
        r.event_class  = CLS_SYSEX;
        r.event_type   = STATUS_SYSEX;
        r.event_length = length;
        return r;
    endfunction

    // Check the declared length of the fixed-size meta types, then report
    function automatic t_result meta_result();
        t_result     r;
        logic [31:0] need;
        logic        fixed;
        r     = '0;
        need  = '0;
        fixed = 1'b1;
        case (meta_type)
            META_EOT:     need = 32'd0;
            META_TEMPO:   need = 32'd3;
            META_SMPTE:   need = 32'd5;
            META_TIMESIG: need = 32'd4;
            META_KEYSIG:  need = 32'd2;
            default:      fixed = 1'b0;
        endcase
        if (fixed && len_acc != need) begin
            r.error_code = ERR_META_LEN;
        end else begin
            r.event_class  = CLS_META;
            r.event_type   = meta_type;
            r.event_length = byte_cnt;
            if (meta_type == META_TEMPO) begin
                r.tempo_value = tempo_acc;
            end
            if (meta_type == META_EOT) begin
                r.track_ended = 1'b1;
                track_over    = 1'b1;
            end
        end
        return r;
    endfunction

    // Advance the parse state by one byte; return 1 when an event or error completes
    function automatic logic parse_byte(input logic [7:0] b, input logic lst, input logic nt,
                                        output t_result res);
        logic [3:0] nib;
        logic       done;
        res  = '0;
        done = 1'b0;
        if (nt) begin
            track_over = 1'b0;
            phase      = PH_IDLE;
        end
        if (track_over) begin
            return 1'b0;
        end
        if (phase == PH_IDLE) begin
            byte_cnt  = '0;
            len_acc   = '0;
            tempo_acc = '0;
        end
        byte_cnt = sat_add32(byte_cnt, 32'd1);

        if (phase == PH_IDLE && b[7]) begin
            run_status = b;
            open_event(b);
            if (lst) begin
                res.error_code = ERR_UNEXP_END;
                done = 1'b1;
            end
        end else if (phase == PH_IDLE && !run_status[7]) begin
            res.error_code = ERR_NO_RUNNING;
            done = 1'b1;
        end else begin
            if (phase == PH_IDLE) begin
                open_event(run_status);
            end
            nib = cur_status[7:4];
            case (phase)
                PH_CH1: begin
                    first_data = b;
                    if (nib == NIB_PROGRAM || nib == NIB_CHAN_PRS) begin
                        res.event_class    = CLS_CHANNEL;
                        res.event_type     = {nib, 4'h0};
                        res.channel_number = cur_status[3:0];
                        res.first_param    = {6'd0, b};
                        res.event_length   = byte_cnt;
                        done = 1'b1;
                    end else if (nib == NIB_SYSTEM) begin
                        res.error_code = ERR_BAD_STATUS;
                        done = 1'b1;
                    end else begin
                        phase = PH_CH2;
                        if (lst) begin
                            res.error_code = ERR_UNEXP_END;
                            done = 1'b1;
                        end
                    end
                end
                PH_CH2: begin
                    res.event_class    = CLS_CHANNEL;
                    res.event_type     = {nib, 4'h0};
                    res.channel_number = cur_status[3:0];
                    res.event_length   = byte_cnt;
                    if (nib == NIB_PITCH) begin
                        res.first_param = {b[6:0], first_data[6:0]};
                    end else begin
                        res.first_param  = {6'd0, first_data};
                        res.second_param = b;
                    end
                    done = 1'b1;
                end
                PH_SXLEN: begin
                    len_acc = ((len_acc << 7) | 32'(b[6:0])) & LEN_MASK;
                    if (b[7]) begin
                        if (lst) begin
                            res.error_code = ERR_UNEXP_END;
                            done = 1'b1;
                        end
                    end else if (len_acc == 0) begin
                        res  = sysex_result(byte_cnt);
                        done = 1'b1;
                    end else begin
                        payload_left = len_acc;
                        if (lst) begin
                            res  = sysex_result(sat_add32(byte_cnt, payload_left));
                            done = 1'b1;
                        end else begin
                            phase = PH_SXSKIP;
                        end
                    end
                end
                PH_SXSKIP: begin
                    payload_left = payload_left - 32'd1;
                    if (payload_left == 0) begin
                        res  = sysex_result(byte_cnt);
                        done = 1'b1;
                    end else if (lst) begin
                        res  = sysex_result(sat_add32(byte_cnt, payload_left));
                        done = 1'b1;
                    end
                end
                PH_MTYPE: begin
                    meta_type = b;
                    len_acc   = '0;
                    tempo_acc = '0;
                    phase     = PH_MLEN;
                    if (lst) begin
                        res.error_code = ERR_UNEXP_END;
                        done = 1'b1;
                    end
                end
                PH_MLEN: begin
                    len_acc = ((len_acc << 7) | 32'(b[6:0])) & LEN_MASK;
                    if (b[7]) begin
                        if (lst) begin
                            res.error_code = ERR_UNEXP_END;
                            done = 1'b1;
                        end
                    end else if (len_acc == 0) begin
                        res  = meta_result();
                        done = 1'b1;
                    end else begin
                        payload_left = len_acc;
                        phase        = PH_MDATA;
                        if (lst) begin
                            res.error_code = ERR_UNEXP_END;
                            done = 1'b1;
                        end
                    end
                end
                PH_MDATA: begin
                    tempo_acc    = {tempo_acc[15:0], b};
                    payload_left = payload_left - 32'd1;
                    if (payload_left == 0) begin
                        res  = meta_result();
                        done = 1'b1;
                    end else if (lst) begin
                        res.error_code = ERR_UNEXP_END;
                        done = 1'b1;
                    end
                end
                default: phase = PH_IDLE;
            endcase
        end
        if (done) begin
            phase = PH_IDLE;
        end
        return done;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] seen);
        $display("ERROR %0t: %s expected 0x%0h got 0x%0h", $time, what, want, seen);
        mismatch_count++;
    endtask

    // Compare each result transfer, then predict from each byte transfer
    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        t_result predicted;
        if (!i_rst_n) begin
            run_status   = '0;
            phase        = PH_IDLE;
            cur_status   = '0;
            meta_type    = '0;
            len_acc      = '0;
            payload_left = '0;
            first_data   = '0;
            tempo_acc    = '0;
            byte_cnt     = '0;
            track_over   = 1'b0;
            parsed_events_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen.event_class    = i_event_class;
                seen.event_type     = i_event_type;
                seen.channel_number = i_channel_number;
                seen.first_param    = i_first_param;
                seen.second_param   = i_second_param;
                seen.tempo_value    = i_tempo_value;
                seen.event_length   = i_event_length;
                seen.error_code     = i_error_code;
                seen.track_ended    = i_track_ended;
                if (parsed_events_q.size() == 0) begin
                    report_mismatch("result with none waiting, length", '0,
                                    seen.event_length);
                end else begin
                    want = parsed_events_q.pop_front();
                    if (seen.event_class !== want.event_class)
                        report_mismatch("event_class", 32'(want.event_class),
                                        32'(seen.event_class));
                    if (seen.event_type !== want.event_type)
                        report_mismatch("event_type", 32'(want.event_type),
                                        32'(seen.event_type));
                    if (seen.channel_number !== want.channel_number)
                        report_mismatch("channel_number", 32'(want.channel_number),
                                        32'(seen.channel_number));
                    if (seen.first_param !== want.first_param)
                        report_mismatch("first_param", 32'(want.first_param),
                                        32'(seen.first_param));
                    if (seen.second_param !== want.second_param)
                        report_mismatch("second_param", 32'(want.second_param),
                                        32'(seen.second_param));
                    if (seen.tempo_value !== want.tempo_value)
                        report_mismatch("tempo_value", 32'(want.tempo_value),
                                        32'(seen.tempo_value));
                    if (seen.event_length !== want.event_length)
                        report_mismatch("event_length", want.event_length, seen.event_length);
                    if (seen.error_code !== want.error_code)
                        report_mismatch("error_code", 32'(want.error_code),
                                        32'(seen.error_code));
                    if (seen.track_ended !== want.track_ended)
                        report_mismatch("track_ended", 32'(want.track_ended),
                                        32'(seen.track_ended));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (parse_byte(i_data_byte, i_last_in_buffer, i_new_track, predicted)) begin
                    parsed_events_q.insert(parsed_events_q.size(), predicted);
                end
            end
            o_pending <= parsed_events_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_midi_track_event_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_track_event_parser
// Feeds the parser a short set of hand-picked track bytes. Then it feeds
// random event sequences: channel messages with and without running status,
// sysex, meta events, end of track, system status bytes and noise. Both
// sides idle and stall at random. The checker does the comparing; this top
// gives the verdict.
// ----------------------------------------------------------------------------
module tb_midi_track_event_parser;
    import mtep_pkg::*;

    localparam int CYCLE_LIMIT  = 300_000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       nt;
    } t_track_byte;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_data = '0;
    logic        in_last = 1'b0;
    logic        in_new_track = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  event_class;
    logic [7:0]  event_type;
    logic [3:0]  channel_number;
    logic [13:0] first_param;
    logic [7:0]  second_param;
    logic [23:0] tempo_value;
    logic [31:0] event_length;
    logic [2:0]  error_code;
    logic        track_ended;
    int          pending;
    int          mismatches;

    t_track_byte track_q[$];
    logic        nt_armed = 1'b0;
    logic        chan_running = 1'b0;
    logic [7:0]  last_chan_status = '0;
    int          cycle_count = 0;
    int          rx_wait = 0;
    int          rx_calm = 0;
    int          rx_draw;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    midi_track_event_parser u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_byte      (in_data),
        .i_last_in_buffer (in_last),
        .i_new_track      (in_new_track),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_event_class    (event_class),
        .o_event_type     (event_type),
        .o_channel_number (channel_number),
        .o_first_param    (first_param),
        .o_second_param   (second_param),
        .o_tempo_value    (tempo_value),
        .o_event_length   (event_length),
        .o_error_code     (error_code),
        .o_track_ended    (track_ended)
    );

    midi_event_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_data_byte      (in_data),
        .i_last_in_buffer (in_last),
        .i_new_track      (in_new_track),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_event_class    (event_class),
        .i_event_type     (event_type),
        .i_channel_number (channel_number),
        .i_first_param    (first_param),
        .i_second_param   (second_param),
        .i_tempo_value    (tempo_value),
        .i_event_length   (event_length),
        .i_error_code     (error_code),
        .i_track_ended    (track_ended),
        .o_pending        (pending),
        .o_mismatches     (mismatches)
    );

    // Abort a run that hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the result side at random after each transfer, with calm stretches
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_wait   <= 0;
        end else if (out_valid && !out_stall) begin
            if (rx_calm > 0) begin
                rx_draw = 0;
                rx_calm = rx_calm - 1;
            end else begin
                rx_draw = $urandom_range(0, 3);
                if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 60);
            end
            rx_wait   <= rx_draw;
            out_stall <= (rx_draw != 0);
        end else if (rx_wait > 0) begin
            rx_wait   <= rx_wait - 1;
            out_stall <= (rx_wait > 1);
        end
    end

    task automatic put(input logic [7:0] d, input logic lst, input logic nt);
        t_track_byte item;
        item = '{data: d, last: lst, nt: nt};
        track_q.insert(track_q.size(), item);
    endtask

    // Random byte: rare end of buffer, rare track restart, plus any armed restart
    task automatic put_rand(input logic [7:0] d);
        put(d, ($urandom_range(0, 39) == 0), nt_armed || ($urandom_range(0, 79) == 0));
        nt_armed = 1'b0;
    endtask

    // Variable-length quantity; with cut set, end the buffer on its final byte
    task automatic put_vlq(input logic [31:0] value, input logic cut);
        logic [6:0] grp [5];
        int         n;
        n = 1;
        grp[0] = value[6:0];
        while (n < 5 && (value >> (7 * n)) != 0) begin
            grp[n] = 7'(value >> (7 * n));
            n++;
        end
        if (!cut && $urandom_range(0, 9) == 0) put_rand(8'h80);
        for (int k = n - 1; k >= 0; k--) begin
            if (cut) begin
                put({k != 0, grp[k]}, k == 0, 1'b0);
            end else begin
                put_rand({k != 0, grp[k]});
            end
        end
    endtask

    function automatic logic [7:0] rand_data();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    // Append one random event, mostly well formed
    task automatic add_random_event();
        int          kind;
        int          n;
        logic [7:0]  status;
        logic [7:0]  mtype;
        logic [31:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            if (chan_running && $urandom_range(0, 2) == 0) begin
                status = last_chan_status;
            end else begin
                status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
                put_rand(status);
                last_chan_status = status;
                chan_running     = 1'b1;
            end
            n = (status[7:4] == NIB_PROGRAM || status[7:4] == NIB_CHAN_PRS) ? 1 : 2;
            repeat (n) put_rand(rand_data());
        end else begin
            chan_running = 1'b0;
            if (kind < 55) begin
                put_rand(STATUS_SYSEX);
                len = $urandom_range(0, 6);
                put_vlq(len, 1'b0);
                repeat (len) put_rand(8'($urandom_range(0, 255)));
            end else if (kind < 75) begin
                put_rand(STATUS_META);
                case ($urandom_range(0, 5))
                    0:       mtype = META_TEMPO;
                    1:       mtype = META_SMPTE;
                    2:       mtype = META_TIMESIG;
                    3:       mtype = META_KEYSIG;
                    default: mtype = 8'($urandom_range(0, 255));
                endcase
                put_rand(mtype);
                case (mtype)
                    META_TEMPO:   len = 3;
                    META_SMPTE:   len = 5;
                    META_TIMESIG: len = 4;
                    META_KEYSIG:  len = 2;
                    default:      len = $urandom_range(0, 8);
                endcase
                if ($urandom_range(0, 4) == 0) len = $urandom_range(0, 6);
                put_vlq(len, 1'b0);
                repeat (len) put_rand(8'($urandom_range(0, 255)));
                if (mtype == META_EOT && len == 0) nt_armed = 1'b1;
            end else if (kind < 79) begin
                // end of track, a few ignored bytes, then a new track
                put_rand(STATUS_META);
                put_rand(META_EOT);
                put_vlq(32'd0, 1'b0);
                repeat ($urandom_range(0, 3)) put_rand(8'($urandom_range(0, 255)));
                nt_armed = 1'b1;
            end else if (kind < 83) begin
                put_rand(8'($urandom_range(8'hF1, 8'hFE)));
                put_rand(rand_data());
            end else if (kind < 86) begin
                // huge sysex cut short right after its length
                put_rand(STATUS_SYSEX);
                len = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF
                                                  : ($urandom() | 32'h0010_0000);
                put_vlq(len, 1'b1);
            end else if (kind < 88) begin
                // huge meta, abandoned by a new track
                put_rand(STATUS_META);
                put_rand(8'($urandom_range(0, 255)));
                put_vlq($urandom() | 32'h0010_0000, 1'b0);
                repeat ($urandom_range(0, 3)) put_rand(8'($urandom_range(0, 255)));
                nt_armed = 1'b1;
            end else begin
                repeat ($urandom_range(1, 3)) put_rand(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int gap;
        int calm_left;
        int n_directed;
        calm_left = 0;

        // Directed bytes
        put(8'h40, 1'b0, 1'b0);                          // data byte, no running status
        put(8'h90, 1'b0, 1'b0);
        put(8'h00, 1'b0, 1'b0);
        put(8'h7F, 1'b0, 1'b0);
        put(8'h7F, 1'b0, 1'b0);                          // running status note on
        put(8'h00, 1'b0, 1'b0);
        put(8'hC5, 1'b0, 1'b0);                          // program change, data bit 7 set
        put(8'hFF, 1'b0, 1'b0);
        put(8'hE3, 1'b0, 1'b0);                          // full-scale pitch bend
        put(8'h7F, 1'b0, 1'b0);
        put(8'h7F, 1'b0, 1'b0);
        put(8'hF1, 1'b0, 1'b0);                          // system status is not supported
        put(8'h12, 1'b0, 1'b0);
        put(STATUS_META, 1'b0, 1'b0);                    // maximum tempo
        put(META_TEMPO, 1'b0, 1'b0);
        put(8'h03, 1'b0, 1'b0);
        put(8'hFF, 1'b0, 1'b0);
        put(8'hFF, 1'b0, 1'b0);
        put(8'hFF, 1'b0, 1'b0);
        put(STATUS_SYSEX, 1'b0, 1'b0);                   // sysex cut by end of buffer
        put(8'h0A, 1'b0, 1'b0);
        put(8'h01, 1'b1, 1'b0);
        put(STATUS_META, 1'b0, 1'b0);                    // end of track
        put(META_EOT, 1'b0, 1'b0);
        put(8'h00, 1'b0, 1'b0);
        put(8'h90, 1'b0, 1'b0);                          // ignored after end of track
        put(8'h80, 1'b1, 1'b1);                          // new track, status alone at end
        n_directed = track_q.size();

        while (track_q.size() < n_directed + RANDOM_ITEMS) add_random_event();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Send each byte after a random gap, waiting out the stall
        for (int i = 0; i < track_q.size(); i++) begin
            if (i == n_directed || (i > 0 && i % 600 == 0)) wait_drained();
            if (calm_left > 0) begin
                gap = 0;
                calm_left--;
            end else begin
                gap = $urandom_range(0, 3);
                if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
            end
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid     <= 1'b1;
            in_data      <= track_q[i].data;
            in_last      <= track_q[i].last;
            in_new_track <= track_q[i].nt;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
